### src/dac_pkg.sv
package dac_pkg;

	// Word memory geometry.
	localparam int unsigned MEM_WORDS = 1000;
	localparam int unsigned ADDR_W = 10;
	localparam int unsigned WORD_W = 32;

	// One input item: a memory write or a single instruction step.
	typedef struct packed {
		logic                     mode;
		logic [ADDR_W-1:0]        load_addr;
		logic signed [WORD_W-1:0] load_value;
	} cmd_item_t;

	// One result item: the machine state after the item.
	typedef struct packed {
		logic [ADDR_W-1:0]        pc;
		logic signed [WORD_W-1:0] accum;
		logic                     halted;
	} res_item_t;

	// Instruction classes after decimal decoding.
	typedef enum logic [3:0] {
		CLS_NONE,
		CLS_LOAD,
		CLS_STORE,
		CLS_ADD,
		CLS_SUB,
		CLS_JUMP,
		CLS_JZERO,
		CLS_JNZERO,
		CLS_END
	} op_cls_t;

	// Decoded instruction word.
	typedef struct packed {
		op_cls_t           cls;
		logic [ADDR_W-1:0] addr;
	} dec_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_PUSH
	} st_t;

	// Request to the word memory.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Status and result from the sequencer to the top level.
	typedef struct packed {
		logic      take;
		logic      clearing;
		logic      push;
		res_item_t res;
	} ctl_out_t;

endpackage

### src/dac_mem.sv
module dac_mem (
	input  logic                        clk,
	input  dac_pkg::mem_req_t           req,
	output logic [dac_pkg::WORD_W-1:0]  rdata
);

	logic [dac_pkg::WORD_W-1:0] ram_q [dac_pkg::MEM_WORDS];
	logic [dac_pkg::WORD_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			ram_q[req.waddr] <= req.wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= ram_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/dac_decode.sv
module dac_decode (
	input  logic [dac_pkg::WORD_W-1:0] word,
	output dac_pkg::dec_t              dec
);

	// Decimal opcodes; the opcode is the word divided by the radix.
	localparam int unsigned OP_RADIX  = 1000;
	localparam int unsigned OP_LOAD   = 0;
	localparam int unsigned OP_STORE  = 5;
	localparam int unsigned OP_ADD    = 10;
	localparam int unsigned OP_SUB    = 15;
	localparam int unsigned OP_JUMP   = 20;
	localparam int unsigned OP_JZERO  = 25;
	localparam int unsigned OP_JNZERO = 30;
	localparam int unsigned OP_END    = 99;

	// Lowest word that carries the given opcode.
	function automatic logic [dac_pkg::WORD_W-1:0] base_of(input int unsigned op);
		return dac_pkg::WORD_W'(op * OP_RADIX);
	endfunction

	// True when the word lies in the band of one opcode.
	function automatic logic in_band(input logic [dac_pkg::WORD_W-1:0] w,
			input int unsigned op);
		logic [dac_pkg::WORD_W-1:0] hi;
		hi = dac_pkg::WORD_W'((op + 1) * OP_RADIX);
		return (w >= base_of(op)) && (w < hi);
	endfunction

	logic [dac_pkg::WORD_W-1:0] base;

	// A band test per opcode replaces the division; negative words do nothing.
	always_comb begin
		priority if (word[dac_pkg::WORD_W-1]) begin
			dec.cls = dac_pkg::CLS_NONE;
			base = '0;
		end else if (in_band(word, OP_LOAD)) begin
			dec.cls = dac_pkg::CLS_LOAD;
			base = base_of(OP_LOAD);
		end else if (in_band(word, OP_STORE)) begin
			dec.cls = dac_pkg::CLS_STORE;
			base = base_of(OP_STORE);
		end else if (in_band(word, OP_ADD)) begin
			dec.cls = dac_pkg::CLS_ADD;
			base = base_of(OP_ADD);
		end else if (in_band(word, OP_SUB)) begin
			dec.cls = dac_pkg::CLS_SUB;
			base = base_of(OP_SUB);
		end else if (in_band(word, OP_JUMP)) begin
			dec.cls = dac_pkg::CLS_JUMP;
			base = base_of(OP_JUMP);
		end else if (in_band(word, OP_JZERO)) begin
			dec.cls = dac_pkg::CLS_JZERO;
			base = base_of(OP_JZERO);
		end else if (in_band(word, OP_JNZERO)) begin
			dec.cls = dac_pkg::CLS_JNZERO;
			base = base_of(OP_JNZERO);
		end else if (in_band(word, OP_END)) begin
			dec.cls = dac_pkg::CLS_END;
			base = base_of(OP_END);
		end else begin
			dec.cls = dac_pkg::CLS_NONE;
			base = '0;
		end
	end

	// The remainder is below the radix, so the low bits of the difference are exact.
	assign dec.addr = word[dac_pkg::ADDR_W-1:0] - base[dac_pkg::ADDR_W-1:0];

endmodule

### src/dac_ctrl.sv
module dac_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  dac_pkg::cmd_item_t         item,
	input  logic                       out_free,
	output dac_pkg::ctl_out_t          ctl,
	output dac_pkg::mem_req_t          req,
	input  logic [dac_pkg::WORD_W-1:0] rdata
);

	localparam logic [dac_pkg::ADDR_W-1:0] LAST_ADDR =
		dac_pkg::ADDR_W'(dac_pkg::MEM_WORDS - 1);

	dac_pkg::st_t              state_q, state_n;
	dac_pkg::op_cls_t          cls_q, cls_n;
	dac_pkg::dec_t             dec;
	logic [dac_pkg::ADDR_W-1:0] clr_q;
	logic [dac_pkg::ADDR_W-1:0] pc_q, pc_n, pc_inc;
	logic signed [dac_pkg::WORD_W-1:0] acc_q, acc_n;
	logic                      halt_q, halt_n;
	logic                      finish;
	logic                      need_opnd;

	dac_decode u_decode (
		.word (rdata),
		.dec  (dec)
	);

	// Load, add and subtract need a second memory read.
	assign need_opnd = (dec.cls == dac_pkg::CLS_LOAD) || (dec.cls == dac_pkg::CLS_ADD) ||
		(dec.cls == dac_pkg::CLS_SUB);
	assign pc_inc = (pc_q == LAST_ADDR) ? '0 : pc_q + 1'b1;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			dac_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_n = dac_pkg::ST_IDLE;
				end
			end
			dac_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (item.mode && !halt_q) begin
						state_n = dac_pkg::ST_DECODE;
					end else if (!out_free) begin
						state_n = dac_pkg::ST_PUSH;
					end
				end
			end
			dac_pkg::ST_DECODE: begin
				if (need_opnd) begin
					state_n = dac_pkg::ST_EXEC;
				end else begin
					state_n = out_free ? dac_pkg::ST_IDLE : dac_pkg::ST_PUSH;
				end
			end
			dac_pkg::ST_EXEC, dac_pkg::ST_PUSH: begin
				state_n = out_free ? dac_pkg::ST_IDLE : dac_pkg::ST_PUSH;
			end
			default: state_n = dac_pkg::ST_IDLE;
		endcase
	end

	// Memory accesses and the next machine state.
	always_comb begin
		req.we = 1'b0;
		req.waddr = item.load_addr;
		req.wdata = item.load_value;
		req.re = 1'b0;
		req.raddr = pc_q;
		ctl.take = 1'b0;
		finish = 1'b0;
		pc_n = pc_q;
		acc_n = acc_q;
		halt_n = halt_q;
		cls_n = cls_q;
		unique case (state_q)
			dac_pkg::ST_CLEAR: begin
				req.we = 1'b1;
				req.waddr = clr_q;
				req.wdata = '0;
			end
			dac_pkg::ST_IDLE: begin
				if (item_valid) begin
					ctl.take = 1'b1;
					if (!item.mode) begin
						req.we = (item.load_addr < dac_pkg::ADDR_W'(dac_pkg::MEM_WORDS));
						finish = 1'b1;
					end else if (halt_q) begin
						finish = 1'b1;
					end else begin
						req.re = 1'b1;
					end
				end
			end
			dac_pkg::ST_DECODE: begin
				pc_n = pc_inc;
				finish = !need_opnd;
				cls_n = dec.cls;
				unique case (dec.cls)
					dac_pkg::CLS_LOAD, dac_pkg::CLS_ADD, dac_pkg::CLS_SUB: begin
						req.re = 1'b1;
						req.raddr = dec.addr;
					end
					dac_pkg::CLS_STORE: begin
						req.we = 1'b1;
						req.waddr = dec.addr;
						req.wdata = acc_q;
					end
					dac_pkg::CLS_JUMP: pc_n = dec.addr;
					dac_pkg::CLS_JZERO: begin
						if (acc_q == '0) begin
							pc_n = dec.addr;
						end
					end
					dac_pkg::CLS_JNZERO: begin
						if (acc_q != '0) begin
							pc_n = dec.addr;
						end
					end
					dac_pkg::CLS_END: halt_n = 1'b1;
					default: ;
				endcase
			end
			dac_pkg::ST_EXEC: begin
				finish = 1'b1;
				unique case (cls_q)
					dac_pkg::CLS_LOAD: acc_n = rdata;
					dac_pkg::CLS_ADD:  acc_n = acc_q + rdata;
					dac_pkg::CLS_SUB:  acc_n = acc_q - rdata;
					default: ;
				endcase
			end
			dac_pkg::ST_PUSH: finish = 1'b1;
			default: ;
		endcase
	end

	// Result and status towards the top level.
	assign ctl.clearing = (state_q == dac_pkg::ST_CLEAR);
	assign ctl.push = finish && out_free;
	assign ctl.res.pc = pc_n;
	assign ctl.res.accum = acc_n;
	assign ctl.res.halted = halt_n;

	// State and machine registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dac_pkg::ST_CLEAR;
			clr_q <= '0;
			pc_q <= '0;
			acc_q <= '0;
			halt_q <= 1'b0;
			cls_q <= dac_pkg::CLS_NONE;
		end else begin
			state_q <= state_n;
			if (state_q == dac_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			pc_q <= pc_n;
			acc_q <= acc_n;
			halt_q <= halt_n;
			cls_q <= cls_n;
		end
	end

endmodule

### src/decimal_accumulator_cpu_unit.sv
// A write item finishes in the idle state; a step fetches its instruction word, and load, add
// and subtract then read their operand: the instruction fetch and then the operand access
// share the single read port of the word memory. A step while halted needs no memory access.
// The result is registered once the item finishes and the output register is free, and one
// further item waits in the input register meanwhile. After reset all 1000 words are swept
// to zero, one word a cycle, with cmd_stall high; pc, accumulator and halt flag reset to zero.
module decimal_accumulator_cpu_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  dac_pkg::cmd_item_t cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output dac_pkg::res_item_t res
);

	dac_pkg::cmd_item_t cmd_q;
	logic               cmd_valid_q;
	dac_pkg::res_item_t res_q;
	logic               res_valid_q;
	dac_pkg::ctl_out_t  ctl;
	dac_pkg::mem_req_t  req;
	logic [dac_pkg::WORD_W-1:0] rdata;
	logic               out_free;

	// Input register: holds one item while the sequencer works on the previous one, and
	// refills in the cycle in which its item is taken.
	assign cmd_stall = (cmd_valid_q && !ctl.take) || ctl.clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			cmd_valid_q <= 1'b1;
		end else if (ctl.take) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_q <= cmd;
		end
	end

	// Output register: a result waits here until it is taken.
	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			res_q <= ctl.res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	dac_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd_valid_q),
		.item       (cmd_q),
		.out_free   (out_free),
		.ctl        (ctl),
		.req        (req),
		.rdata      (rdata)
	);

	dac_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

### test/dac_opcodes_pkg.sv
`timescale 1ns / 100ps
package dac_opcodes_pkg;

	// An instruction word holds opcode * WORD_RADIX + address.
	localparam int unsigned WORD_RADIX = 1000;

	// Decimal opcodes understood by the machine.
	localparam int unsigned OPC_LOAD   = 0;
	localparam int unsigned OPC_STORE  = 5;
	localparam int unsigned OPC_ADD    = 10;
	localparam int unsigned OPC_SUB    = 15;
	localparam int unsigned OPC_JUMP   = 20;
	localparam int unsigned OPC_JZERO  = 25;
	localparam int unsigned OPC_JNZERO = 30;
	localparam int unsigned OPC_END    = 99;

	// Item kinds carried in the mode field.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EXEC  = 1'b1;

endpackage

### test/dac_state_checker.sv
`timescale 1ns / 100ps
module dac_state_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  dac_pkg::cmd_item_t cmd,
	input  logic               res_valid,
	input  logic               res_stall,
	input  dac_pkg::res_item_t res,
	output int                 mismatches,
	output int                 pending
);
	import dac_pkg::*;
	import dac_opcodes_pkg::*;

	// Shadow copy of the machine.
	logic [WORD_W-1:0] word_mem [MEM_WORDS];
	logic [ADDR_W-1:0] pc_now;
	logic [WORD_W-1:0] acc_now;
	logic              halt_now;

	// Machine states still owed by the block, oldest first.
	res_item_t states_due [$];

	// Print one line per mismatch and count it.
	task automatic report(input string what);
		$display("%0t ns checker: %s", $time, what);
		mismatches++;
	endtask

	// Apply one item to the shadow machine.
	task automatic advance_machine(input cmd_item_t c);
		logic [WORD_W-1:0] word;
		logic [ADDR_W-1:0] nxt;
		int unsigned       opc;
		int unsigned       arg;
		if (c.mode == MODE_WRITE) begin
			// Writes beyond the top of memory are dropped; writes while halted still land.
			if (c.load_addr < MEM_WORDS) begin
				word_mem[c.load_addr] = c.load_value;
			end
		end else if (!halt_now) begin
			word = word_mem[pc_now];
			nxt = (pc_now == MEM_WORDS - 1) ? '0 : pc_now + 1'b1;
			// A negative word does nothing but advance the pointer.
			if (!word[WORD_W-1]) begin
				opc = word / WORD_RADIX;
				arg = word % WORD_RADIX;
				case (opc)
					OPC_LOAD:   acc_now = word_mem[arg];
					OPC_STORE:  word_mem[arg] = acc_now;
					OPC_ADD:    acc_now = acc_now + word_mem[arg];
					OPC_SUB:    acc_now = acc_now - word_mem[arg];
					OPC_JUMP:   nxt = arg[ADDR_W-1:0];
					OPC_JZERO:  if (acc_now == '0) nxt = arg[ADDR_W-1:0];
					OPC_JNZERO: if (acc_now != '0) nxt = arg[ADDR_W-1:0];
					OPC_END:    halt_now = 1'b1;
					default: ;
				endcase
			end
			pc_now = nxt;
		end
	endtask

	// Compare results against the oldest owed state, then predict for the new item.
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_WORDS; i++) begin
				word_mem[i] = '0;
			end
			pc_now = '0;
			acc_now = '0;
			halt_now = 1'b0;
			states_due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (states_due.size() == 0) begin
					report("result item arrived with none outstanding");
				end else begin
					want = states_due.pop_front();
					if (res.pc !== want.pc) begin
						report($sformatf("pc %0d, expected %0d", res.pc, want.pc));
					end
					if (res.accum !== want.accum) begin
						report($sformatf("accum %0d, expected %0d", res.accum, want.accum));
					end
					if (res.halted !== want.halted) begin
						report($sformatf("halted %b, expected %b", res.halted, want.halted));
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				advance_machine(cmd);
				want.pc = pc_now;
				want.accum = acc_now;
				want.halted = halt_now;
				states_due.push_back(want);
			end
			pending <= states_due.size();
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import dac_pkg::*;
	import dac_opcodes_pkg::*;

	typedef enum int {STALL_NONE, STALL_SOME, STALL_MOST, STALL_BEAT} stall_style_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cmd_valid = 1'b0;
	logic         cmd_stall;
	cmd_item_t    cmd = '0;
	logic         res_valid;
	logic         res_stall = 1'b0;
	res_item_t    res;
	int           mismatches;
	int           pending;
	logic [ADDR_W-1:0] last_pc = '0;
	int           items = 0;
	int           burst_left = 0;
	stall_style_t stall_style = STALL_NONE;
	int           stall_tick = 0;
	int unsigned  data_at [4];

	decimal_accumulator_cpu_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	dac_state_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Give up after a generous fixed time.
	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Receiver stalls: a stall style is drawn at random and rules res_stall until it is redrawn.
	always @(posedge clk) begin
		if (stall_tick % 48 == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
		end
		stall_tick <= stall_tick + 1;
		case (stall_style)
			STALL_NONE: res_stall <= 1'b0;
			STALL_SOME: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_MOST: res_stall <= ($urandom_range(0, 3) != 0);
			default:    res_stall <= (stall_tick % 7) < 3;
		endcase
	end

	// Track where the machine stands so that new programs can be jumped into.
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			last_pc <= res.pc;
		end
	end

	function automatic logic [WORD_W-1:0] instr(input int unsigned opc, input int unsigned addr);
		return opc * WORD_RADIX + addr;
	endfunction

	// Operand values, weighted towards zero, small numbers and the extremes.
	function automatic logic [WORD_W-1:0] rand_data();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return $urandom_range(1, 40);
			2:       return ~($urandom_range(0, 39));
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// One instruction of a random program laid out from base; jumps stay near the program.
	function automatic logic [WORD_W-1:0] rand_instr(input int unsigned base,
			input int unsigned len);
		int unsigned tgt;
		int unsigned opc;
		tgt = (base + $urandom_range(0, len)) % WORD_RADIX;
		case ($urandom_range(0, 11))
			0, 1:    return instr(OPC_LOAD, data_at[$urandom_range(0, 3)]);
			2:       return instr(OPC_STORE, data_at[$urandom_range(0, 3)]);
			3, 4:    return instr(OPC_ADD, data_at[$urandom_range(0, 3)]);
			5:       return instr(OPC_SUB, data_at[$urandom_range(0, 3)]);
			6:       return instr(OPC_JUMP, tgt);
			7:       return instr(OPC_JZERO, tgt);
			8:       return instr(OPC_JNZERO, tgt);
			9: begin
				// Unknown opcode below the end code.
				do opc = $urandom_range(1, 98);
				while (opc % 5 == 0 && opc <= OPC_JNZERO);
				return instr(opc, $urandom_range(0, MEM_WORDS - 1));
			end
			10:      return $urandom_range(100_000, 32'h7FFF_FFFF);
			default: return $urandom | 32'h8000_0000;
		endcase
	endfunction

	// Offer one item, wait until it is taken, then maybe open a gap in the burst.
	task automatic send_cmd(input logic m, input int unsigned a, input logic [WORD_W-1:0] v);
		cmd <= '{mode: m, load_addr: a[ADDR_W-1:0], load_value: v};
		cmd_valid <= 1'b1;
		do @(posedge clk);
		while (cmd_stall);
		items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(0, 8);
		end
	endtask

	task automatic write_word(input int unsigned a, input logic [WORD_W-1:0] v);
		send_cmd(MODE_WRITE, a, v);
	endtask

	task automatic step_once();
		send_cmd(MODE_EXEC, $urandom_range(0, 1023), $urandom);
	endtask

	// Hold off until every owed result has come back.
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int unsigned base;
		int unsigned len;
		int unsigned steps;
		int unsigned cur;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed program: extremes, every opcode but the end code, wrap of the pointer and dropped writes.
		write_word(500, 32'h7FFF_FFFF);
		write_word(999, 32'h8000_0000);
		write_word(1023, 32'hFFFF_FFFF);
		write_word(0, instr(OPC_LOAD, 500));
		write_word(1, instr(OPC_ADD, 500));
		write_word(2, instr(OPC_SUB, 999));
		write_word(3, instr(OPC_STORE, 502));
		write_word(4, instr(OPC_JZERO, 0));
		write_word(5, instr(OPC_JNZERO, 7));
		write_word(7, instr(42, 7));
		write_word(8, instr(OPC_LOAD, 501));
		write_word(9, instr(OPC_JZERO, 11));
		write_word(11, instr(OPC_JUMP, 998));
		repeat (12) step_once();

		// Random programs with random contents, each entered by a jump from the current pointer.
		while (items < 500) begin
			settle();
			cur = last_pc;
			base = $urandom_range(0, MEM_WORDS - 1);
			len = $urandom_range(3, 10);
			for (int i = 0; i < 4; i++) begin
				data_at[i] = $urandom_range(0, MEM_WORDS - 1);
				write_word(data_at[i], rand_data());
			end
			for (int i = 0; i < len; i++) begin
				write_word((base + i) % WORD_RADIX, rand_instr(base, len));
			end
			write_word(cur, instr(OPC_JUMP, base));
			steps = $urandom_range(len, 3 * len);
			for (int i = 0; i < steps; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					write_word($urandom_range(0, 1023), rand_data());
				end else begin
					step_once();
				end
			end
		end

		// Halt the machine, then check that steps and writes leave the reported state alone.
		settle();
		write_word(last_pc, instr(OPC_END, $urandom_range(0, MEM_WORDS - 1)));
		repeat (4) step_once();
		write_word($urandom_range(0, MEM_WORDS - 1), $urandom);
		step_once();
		settle();
		repeat (16) @(posedge clk);

		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

### files.f
src/dac_pkg.sv
src/dac_mem.sv
src/dac_decode.sv
src/dac_ctrl.sv
src/decimal_accumulator_cpu_unit.sv
test/dac_opcodes_pkg.sv
test/dac_state_checker.sv
test/testbench.sv
